FILE: design/ir_ring_direction_finder_unit_defines.svh
// assertion helpers for the direction finder
`ifndef IR_RING_DIRECTION_FINDER_UNIT_DEFINES_SVH
`define IR_RING_DIRECTION_FINDER_UNIT_DEFINES_SVH

// same-cycle implication, held off during reset
`define IRDF_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, held off during reset
`define IRDF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/irdf_pkg.sv
package irdf_pkg;

    localparam logic [15:0] ENABLE_RESET = 16'hF01F;

    typedef struct packed {
        logic [15:0] sensor_levels;
        logic        window_end;
    } irdf_in_t;

    typedef struct packed {
        logic [3:0] angle;
        logic [3:0] distance;
        logic       ball_found;
        logic [7:0] packed_byte;
    } irdf_out_t;

    // sequencer commands to the shared scan unit
    typedef struct packed {
        logic clear;
        logic step;
    } irdf_scan_ctrl_t;

endpackage

FILE: design/irdf_scan_unit.sv
module irdf_scan_unit #(
    parameter int NUM_RECEIVERS = 16,
    parameter int COUNT_BITS    = 10
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  irdf_pkg::irdf_scan_ctrl_t   ctrl,
    input  logic [$clog2(NUM_RECEIVERS)-1:0] idx,
    input  logic [COUNT_BITS-1:0]       count_in,
    input  logic                        hit,
    output logic [COUNT_BITS-1:0]       count_out,
    output irdf_pkg::irdf_out_t         summary
);
    import irdf_pkg::*;

    localparam int IDX_W = $clog2(NUM_RECEIVERS);
    localparam int TW    = $clog2(NUM_RECEIVERS + 1);

    logic [COUNT_BITS-1:0] best_reg, best_next;
    logic [IDX_W-1:0]      angle_reg, angle_next;
    logic [TW-1:0]         tally_reg, tally_next;
    logic [TW-1:0]         distance_raw;
    logic [3:0]            angle4;
    logic [3:0]            dist4;
    logic                  greater;

    // saturating increment of the receiver under the sequencer's index
    assign count_out = (hit && (count_in != '1)) ? count_in + COUNT_BITS'(1) : count_in;
    assign greater   = count_out > best_reg;

    always_comb
    begin
        best_next  = best_reg;
        angle_next = angle_reg;
        tally_next = tally_reg;
        if (ctrl.clear)
        begin
            best_next  = '0;
            angle_next = '0;
            tally_next = '0;
        end
        else if (ctrl.step)
        begin
            // strict compare keeps the lowest index on ties
            if (greater)
            begin
                best_next  = count_out;
                angle_next = idx;
            end
            if (count_out != '0)
                tally_next = tally_reg + TW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_reg  <= '0;
            angle_reg <= '0;
            tally_reg <= '0;
        end
        else
        begin
            best_reg  <= best_next;
            angle_reg <= angle_next;
            tally_reg <= tally_next;
        end
    end

    assign distance_raw = (tally_reg > TW'(1)) ? tally_reg - TW'(1) : tally_reg;
    assign angle4       = 4'(angle_reg);
    assign dist4        = 4'(distance_raw);

    assign summary.angle       = angle4;
    assign summary.distance    = dist4;
    assign summary.ball_found  = dist4 != 4'd0;
    assign summary.packed_byte = {dist4, angle4};

endmodule

FILE: design/ir_ring_direction_finder_unit.sv
// ir ring direction finder
// input: a word (sensor_levels, window_end) is taken when start is high and busy
// is low. sensor bits are active low; each enabled receiver that reads low adds
// one to its saturating hit counter.
// one shared step unit visits one receiver per clock, so every word keeps the
// block busy until all NUM_RECEIVERS receivers (16 by default) are visited;
// busy then drops, and no new word is taken before that pass is done.
// on a word with window_end set the same pass also tracks the largest counter
// and the count of nonzero counters and clears each counter behind it. the
// result word (angle, distance, ball_found, packed_byte) is then shown for one
// cycle with result_valid high, registered from the end of the pass, with busy low.
// the receiver cannot stall: a result not taken in its strobe cycle is gone.
// cfg channel: cfg_data is the receiver enable mask, written when cfg_valid is
// high (cfg_ready is always high); write it only while the block is idle.
// reset: counters cleared, mask 0xF01F, block idle, no result pending.
module ir_ring_direction_finder_unit #(
    parameter int NUM_RECEIVERS = 16,
    parameter int COUNT_BITS    = 10
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  irdf_pkg::irdf_in_t   item,
    output logic                 result_valid,
    output irdf_pkg::irdf_out_t  result,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [15:0]          cfg_data
);
    `include "ir_ring_direction_finder_unit_defines.svh"
    import irdf_pkg::*;

    localparam int IDX_W = $clog2(NUM_RECEIVERS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_RECEIVERS - 1);

    typedef enum logic {S_IDLE, S_RUN} state_t;

    state_t                   state_reg, state_next;
    logic [IDX_W-1:0]         idx_reg, idx_next;
    logic                     last_reg, last_next;
    logic [NUM_RECEIVERS-1:0] levels_reg, levels_next;
    logic [NUM_RECEIVERS-1:0] mask_reg, mask_next;
    logic                     done_reg, done_next;
    logic [COUNT_BITS-1:0]    counts_reg [NUM_RECEIVERS];
    logic [COUNT_BITS-1:0]    counts_next [NUM_RECEIVERS];

    logic                     accept;
    logic                     hit;
    logic [COUNT_BITS-1:0]    count_new;
    irdf_scan_ctrl_t          scan_ctrl;
    irdf_out_t                summary;

    assign busy      = state_reg == S_RUN;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;
    assign hit       = mask_reg[idx_reg] && !levels_reg[idx_reg];

    assign scan_ctrl.clear = accept;
    assign scan_ctrl.step  = busy && last_reg;

    irdf_scan_unit #(
        .NUM_RECEIVERS (NUM_RECEIVERS),
        .COUNT_BITS    (COUNT_BITS)
    ) u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (scan_ctrl),
        .idx       (idx_reg),
        .count_in  (counts_reg[idx_reg]),
        .hit       (hit),
        .count_out (count_new),
        .summary   (summary)
    );

    always_comb
    begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        last_next   = last_reg;
        levels_next = levels_reg;
        mask_next   = mask_reg;
        done_next   = 1'b0;
        counts_next = counts_reg;

        if (cfg_valid && cfg_ready)
            mask_next = cfg_data[NUM_RECEIVERS-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    levels_next = item.sensor_levels[NUM_RECEIVERS-1:0];
                    last_next   = item.window_end;
                    idx_next    = '0;
                    state_next  = S_RUN;
                end
            end
            S_RUN:
            begin
                // window end clears each counter once its value is scanned
                counts_next[idx_reg] = last_reg ? '0 : count_new;
                if (idx_reg == LAST_IDX)
                begin
                    done_next  = last_reg;
                    state_next = S_IDLE;
                end
                else
                    idx_next = idx_reg + IDX_W'(1);
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            idx_reg    <= '0;
            last_reg   <= 1'b0;
            levels_reg <= '1;
            mask_reg   <= ENABLE_RESET[NUM_RECEIVERS-1:0];
            done_reg   <= 1'b0;
            for (int i = 0; i < NUM_RECEIVERS; i++)
                counts_reg[i] <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            idx_reg    <= idx_next;
            last_reg   <= last_next;
            levels_reg <= levels_next;
            mask_reg   <= mask_next;
            done_reg   <= done_next;
            counts_reg <= counts_next;
        end
    end

    assign result_valid = done_reg;
    assign result       = summary;

    `IRDF_ASSERT_NEXT(a_accept_runs, clk, rst_n, accept, busy && (idx_reg == '0), "accepted word did not start a pass at receiver zero")
    `IRDF_ASSERT_NOW(a_done_idle, clk, rst_n, done_reg, !busy && $past(busy) && $past(last_reg), "result strobe outside the end of a window pass")
    `IRDF_ASSERT_NOW(a_pass_full, clk, rst_n, $fell(busy), $past(idx_reg) == LAST_IDX, "pass ended before visiting every receiver")
    `IRDF_ASSERT_NOW(a_found_match, clk, rst_n, result_valid, result.ball_found == (result.distance != 4'd0), "ball_found disagrees with distance")

endmodule

FILE: tb/sv/tb_ir_ring_direction_finder_unit.sv
`timescale 1ns / 100ps

module tb_ir_ring_direction_finder_unit;
    import irdf_pkg::*;

    localparam int NUM_RX   = 16;
    localparam int CNT_BITS = 10;
    localparam int SETTLE   = NUM_RX + 4;

    // predicts the bearing word produced at each window end
    class direction_scoreboard;
        bit [CNT_BITS-1:0] hit_counts[NUM_RX];
        bit [15:0]         enable_mask;
        irdf_out_t         expected_bearings[$];
        int                mismatches;

        function new();
            foreach (hit_counts[i])
            begin
                hit_counts[i] = '0;
            end
            enable_mask = ENABLE_RESET;
            mismatches  = 0;
        endfunction

        function void set_mask(bit [15:0] m);
            enable_mask = m;
        endfunction

        function int pending();
            return expected_bearings.size();
        endfunction

        function void note_sample(irdf_in_t w);
            bit [CNT_BITS-1:0] best;
            int                idx;
            int                nonzero;
            irdf_out_t         r;
            for (int i = 0; i < NUM_RX; i++)
            begin
                if (enable_mask[i] && !w.sensor_levels[i] && hit_counts[i] != '1)
                    hit_counts[i]++;
            end
            if (!w.window_end)
                return;
            best    = '0;
            idx     = 0;
            nonzero = 0;
            for (int i = 0; i < NUM_RX; i++)
            begin
                // strict compare, so the lowest index keeps a tie
                if (hit_counts[i] > best)
                begin
                    best = hit_counts[i];
                    idx  = i;
                end
                if (hit_counts[i] != 0)
                    nonzero++;
            end
            if (nonzero > 1)
                nonzero--;
            r.angle       = idx[3:0];
            r.distance    = nonzero[3:0];
            r.ball_found  = (nonzero != 0);
            r.packed_byte = {r.distance, r.angle};
            expected_bearings.push_back(r);
            foreach (hit_counts[i])
            begin
                hit_counts[i] = '0;
            end
        endfunction

        function void report(string what, logic [7:0] exp_v, logic [7:0] got_v);
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch at %0t: %s expected %0h, got %0h", $time, what, exp_v,
                    got_v);
        endfunction

        function void check_result(irdf_out_t got);
            irdf_out_t want;
            if (expected_bearings.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch at %0t: result word with none expected, got %h",
                        $time, got);
                return;
            end
            want = expected_bearings.pop_front();
            if (got.angle !== want.angle)
                report("angle", 8'(want.angle), 8'(got.angle));
            if (got.distance !== want.distance)
                report("distance", 8'(want.distance), 8'(got.distance));
            if (got.ball_found !== want.ball_found)
                report("ball_found", 8'(want.ball_found), 8'(got.ball_found));
            if (got.packed_byte !== want.packed_byte)
                report("packed_byte", want.packed_byte, got.packed_byte);
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    irdf_in_t    item = '0;
    logic        result_valid;
    irdf_out_t   result;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_data = '0;

    direction_scoreboard sb = new();

    ir_ring_direction_finder_unit #(
        .NUM_RECEIVERS(NUM_RX),
        .COUNT_BITS   (CNT_BITS)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .item        (item),
        .result_valid(result_valid),
        .result      (result),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && result_valid)
            sb.check_result(result);
    end

    initial
    begin
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

    // start stays high after a word is taken; the next call decides whether it drops
    task automatic send_sample(input logic [15:0] levels, input logic last, input int gap);
        irdf_in_t w;
        w.sensor_levels = levels;
        w.window_end    = last;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        item  <= w;
        do @(posedge clk); while (busy);
        sb.note_sample(w);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        while (busy) @(posedge clk);
    endtask

    task automatic write_enable_mask(input logic [15:0] m);
        repeat ($urandom_range(0, 3)) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= m;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.set_mask(m);
    endtask

    function automatic logic [15:0] make_levels();
        case ($urandom_range(0, 4))
            0: return 16'($urandom);
            1: return 16'hFFFF;
            2: return ~(16'h0001 << $urandom_range(0, 15));
            3: return 16'($urandom | $urandom);
            default: return 16'($urandom & $urandom);
        endcase
    endfunction

    // whole windows of random length until at least n words have gone in
    task automatic run_windows(input int n, input bit idling);
        int  sent;
        int  wlen;
        bit  idle_on;
        sent = 0;
        while (sent < n)
        begin
            wlen    = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                   : $urandom_range(1, 6);
            idle_on = idling && ($urandom_range(0, 2) != 0);
            for (int k = 0; k < wlen; k++)
            begin
                send_sample(make_levels(), k == wlen - 1,
                    (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0);
                sent++;
            end
        end
    endtask

    initial
    begin
        logic [15:0] levels;
        logic [15:0] masks[8];

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // reset mask: nothing seen, all seen, a two-receiver window, a disabled receiver
        send_sample(16'hFFFF, 1'b1, 0);
        send_sample(16'h0000, 1'b1, 0);
        send_sample(16'h7FFF, 1'b0, 0);
        send_sample(16'h7FFF, 1'b0, 2);
        send_sample(16'hFFFE, 1'b1, 0);
        send_sample(16'hFFDF, 1'b1, 0);
        send_sample(16'hFFFE, 1'b1, 0);
        send_sample(16'hBFFF, 1'b1, 0);
        drain();

        write_enable_mask(16'hFFFF);
        send_sample(16'h0000, 1'b1, 0);
        send_sample(16'hFFFF, 1'b0, 0);
        send_sample(16'h0000, 1'b1, 0);
        send_sample(16'h5555, 1'b0, 0);
        send_sample(16'hAAAA, 1'b1, 0);
        drain();

        // counts taken with everything masked must not show up later
        write_enable_mask(16'h0000);
        send_sample(16'h0000, 1'b1, 0);
        send_sample(16'h0000, 1'b0, 0);
        drain();
        write_enable_mask(16'hFFFF);
        send_sample(16'hFFFF, 1'b1, 0);

        // saturation: receiver 9 sees 1030 hits, receiver 3 sees 1023, tie goes to 3
        for (int i = 0; i < 1030; i++)
        begin
            levels    = 16'($urandom);
            levels[9] = 1'b0;
            levels[3] = (i < 7);
            send_sample(levels, i == 1029,
                ($urandom_range(0, 15) == 0) ? $urandom_range(1, 8) : 0);
        end
        drain();

        masks[0] = 16'($urandom);
        masks[1] = 16'h0001;
        masks[2] = 16'h8000;
        masks[3] = ENABLE_RESET;
        masks[4] = 16'($urandom);
        masks[5] = 16'hFFFF;
        masks[6] = 16'($urandom);
        masks[7] = 16'hFFFF;
        for (int p = 0; p < 8; p++)
        begin
            write_enable_mask(masks[p]);
            run_windows(85, p < 6);
            drain();
        end

        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

FILE: ir_ring_direction_finder_unit.f
+incdir+design
design/irdf_pkg.sv
design/irdf_scan_unit.sv
design/ir_ring_direction_finder_unit.sv
tb/sv/tb_ir_ring_direction_finder_unit.sv
